/* rtl/kce_pkg.sv */
// Shared types and constants of the k-means cluster engine.
`default_nettype none
package kce_pkg;

  // Item operation codes.
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Cycles from the last distance issue to the last label write.
  localparam int DRAIN_CYCLES = 4;
  localparam int DRAIN_W      = 2;

  // Configuration register indexes.
  localparam logic [1:0] REG_NUM_CLUSTERS    = 2'd0;
  localparam logic [1:0] REG_NUM_POINTS      = 2'd1;
  localparam logic [1:0] REG_ITERATION_LIMIT = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic lbl_rd_op;
    logic lbl_clr;
    logic res_read;
    logic res_run;
    logic seed_rd;
    logic asg_issue;
    logic first_d;
    logic last_d;
    logic last_c;
    logic clr_wr;
    logic cnt_clr;
    logic cnt_rd_lbl;
    logic cnt_wr;
    logic acc_rd;
    logic acc_wr;
    logic div_start;
    logic cen_wr_div;
  } kce_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic div_done;
  } kce_stat_t;

endpackage
`default_nettype wire

/* rtl/kmeans_cluster_engine.sv */
// Top level of the k-means cluster engine: register port, controller and datapath.
//
//   channel   signals                                   word accepted when
//   -------   ---------------------------------------   --------------------------
//   command   start, opcode, coordinate, point_index,   start && !busy
//             dim_index
//   result    result_strobe, point_echo, cluster_label, result_strobe (one cycle)
//             run_done
//   config    psel, penable, pwrite, paddr, pwdata,     psel && penable && pwrite
//             prdata, pready
//
// A load writes the point memory when it is accepted. A label read passes through
// S_RDRES and its result word is registered from the label memory. A run seeds the
// centroids, then per iteration issues the distances, drains the distance pipeline,
// clears the sums and counts, accumulates the points and divides each non-empty sum
// by its count, paced by the single-port memories and the bit-serial divider, and
// ends with the result word. After reset a label clearing pass holds busy high.
`default_nettype none
module kmeans_cluster_engine #(
  parameter int DIMS         = 16,
  parameter int MAX_POINTS   = 256,
  parameter int MAX_CLUSTERS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         opcode,
  input  wire logic signed [15:0] coordinate,
  input  wire logic [7:0]         point_index,
  input  wire logic [3:0]         dim_index,
  output logic                    result_strobe,
  output logic [7:0]              point_echo,
  output logic [2:0]              cluster_label,
  output logic                    run_done,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int DIM_W = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int PT_W  = $clog2(MAX_POINTS);
  localparam int CL_W  = $clog2(MAX_CLUSTERS);

  logic [3:0]         num_clusters;
  logic [8:0]         num_points;
  logic [9:0]         iteration_limit;
  logic               cfg_wr;
  kce_pkg::kce_cmd_t  cmd;
  kce_pkg::kce_stat_t stat;
  logic [PT_W-1:0]    p_idx;
  logic [CL_W-1:0]    c_idx;
  logic [DIM_W-1:0]   d_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters    <= 4'd5;
      num_points      <= 9'd256;
      iteration_limit <= 10'd300;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        kce_pkg::REG_NUM_CLUSTERS:    num_clusters    <= pwdata[3:0];
        kce_pkg::REG_NUM_POINTS:      num_points      <= pwdata[8:0];
        kce_pkg::REG_ITERATION_LIMIT: iteration_limit <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[3:2])
      kce_pkg::REG_NUM_CLUSTERS:    prdata = 32'(num_clusters);
      kce_pkg::REG_NUM_POINTS:      prdata = 32'(num_points);
      kce_pkg::REG_ITERATION_LIMIT: prdata = 32'(iteration_limit);
      default:                      prdata = '0;
    endcase
  end

  kce_ctrl #(
    .DIMS         (DIMS),
    .MAX_POINTS   (MAX_POINTS),
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .opcode          (opcode),
    .num_clusters    (num_clusters),
    .num_points      (num_points),
    .iteration_limit (iteration_limit),
    .stat            (stat),
    .busy            (busy),
    .cmd             (cmd),
    .p_idx           (p_idx),
    .c_idx           (c_idx),
    .d_idx           (d_idx)
  );

  kce_datapath #(
    .DIMS         (DIMS),
    .MAX_POINTS   (MAX_POINTS),
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .p_idx         (p_idx),
    .c_idx         (c_idx),
    .d_idx         (d_idx),
    .coordinate    (coordinate),
    .point_index   (point_index),
    .dim_index     (dim_index),
    .stat          (stat),
    .result_strobe (result_strobe),
    .point_echo    (point_echo),
    .cluster_label (cluster_label),
    .run_done      (run_done)
  );

endmodule
`default_nettype wire

/* rtl/kce_div.sv */
// Bit-serial signed divider by an unsigned count, truncating toward zero.
`default_nettype none
module kce_div #(
  parameter int DVD_W = 24,
  parameter int DVS_W = 9
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0]        divisor,
  output logic                         done,
  output logic signed [DVD_W-1:0]      quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] work;
  logic [DVS_W:0]   rem;
  logic [DVS_W-1:0] dvs;
  logic             neg;
  logic             running;
  logic [STEP_W-1:0] steps;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  // One quotient bit per cycle by restoring division.
  assign rem_sh = {rem[DVS_W-1:0], work[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= '0;
      end else if (running) begin
        steps <= steps + 1'b1;
        if (steps == STEP_W'(DVD_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend[DVD_W-1] ? DVD_W'(-dividend) : dividend;
      neg  <= dividend[DVD_W-1];
      dvs  <= divisor;
      rem  <= '0;
    end else if (running) begin
      rem  <= fits ? rem_sh - {1'b0, dvs} : rem_sh;
      work <= {work[DVD_W-2:0], fits};
    end
  end

  assign quotient = neg ? -$signed(work) : $signed(work);

endmodule
`default_nettype wire

/* rtl/kce_datapath.sv */
// Datapath: point, centroid, label, sum and count memories with distance pipeline.
`default_nettype none
module kce_datapath #(
  parameter int DIMS         = 16,
  parameter int MAX_POINTS   = 256,
  parameter int MAX_CLUSTERS = 8,
  localparam int DIM_W   = (DIMS > 1) ? $clog2(DIMS) : 1,
  localparam int PT_W    = $clog2(MAX_POINTS),
  localparam int CL_W    = $clog2(MAX_CLUSTERS)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire kce_pkg::kce_cmd_t  cmd,
  input  wire logic [PT_W-1:0]    p_idx,
  input  wire logic [CL_W-1:0]    c_idx,
  input  wire logic [DIM_W-1:0]   d_idx,
  input  wire logic signed [15:0] coordinate,
  input  wire logic [7:0]         point_index,
  input  wire logic [3:0]         dim_index,
  output kce_pkg::kce_stat_t      stat,
  output logic                    result_strobe,
  output logic [7:0]              point_echo,
  output logic [2:0]              cluster_label,
  output logic                    run_done
);

  localparam int PADDR_W = $clog2(MAX_POINTS * DIMS);
  localparam int CADDR_W = $clog2(MAX_CLUSTERS * DIMS);
  localparam int SUM_W   = 16 + $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int DIST_W  = 32 + DIM_W;

  typedef struct packed {
    logic            vld;
    logic            first_d;
    logic            last_d;
    logic            last_c;
    logic [CL_W-1:0] cl;
    logic [PT_W-1:0] pt;
  } tag_t;

  logic signed [15:0]    pt_mem  [MAX_POINTS*DIMS];
  logic signed [15:0]    cen_mem [MAX_CLUSTERS*DIMS];
  logic [CL_W-1:0]       lbl_mem [MAX_POINTS];
  logic signed [SUM_W-1:0] sum_mem [MAX_CLUSTERS*DIMS];
  logic [CNT_W-1:0]      cnt_mem [MAX_CLUSTERS];

  logic signed [15:0]    pt_rd;
  logic signed [15:0]    cen_rd;
  logic [CL_W-1:0]       lbl_rd;
  logic signed [SUM_W-1:0] sum_rd;
  logic [CNT_W-1:0]      cnt_rd;

  logic [CL_W-1:0]       cur_label;
  logic                  seed_pend;
  logic [CADDR_W-1:0]    seed_caddr;
  logic [7:0]            echo_hold;
  logic                  echo_ok;

  tag_t                  t1, t2, t3, t4;
  logic [15:0]           mag2;
  logic [31:0]           sq3;
  logic [DIST_W-1:0]     acc4;
  logic [DIST_W-1:0]     best_d;
  logic [CL_W-1:0]       best_c;
  logic                  take;
  logic [CL_W-1:0]       new_label;

  logic                  div_done;
  logic signed [SUM_W-1:0] quot;

  logic [PT_W-1:0]       pt_sel;
  logic [PADDR_W-1:0]    pt_raddr;
  logic [PADDR_W-1:0]    ld_addr;
  logic                  ld_ok;
  logic [CADDR_W-1:0]    cd_addr;
  logic [CADDR_W-1:0]    ld_cd_addr;
  logic [CADDR_W-1:0]    asg_caddr;
  logic [PT_W-1:0]       lbl_raddr;
  logic [CL_W-1:0]       cnt_raddr;
  logic signed [16:0]    diff1;

  function automatic logic [CADDR_W-1:0] caddr(input logic [CL_W-1:0] c,
                                               input logic [DIM_W-1:0] d);
    return CADDR_W'(CADDR_W'(c) * CADDR_W'(DIMS) + CADDR_W'(d));
  endfunction

  // Address selection.
  assign pt_sel     = cmd.seed_rd ? PT_W'(c_idx) : p_idx;
  assign pt_raddr   = PADDR_W'(PADDR_W'(pt_sel) * PADDR_W'(DIMS) + PADDR_W'(d_idx));
  assign ld_addr    = PADDR_W'(PADDR_W'(point_index) * PADDR_W'(DIMS) + PADDR_W'(dim_index));
  assign ld_ok      = (int'(dim_index) < DIMS) && (int'(point_index) < MAX_POINTS);
  assign cd_addr    = caddr(c_idx, d_idx);
  assign ld_cd_addr = caddr(cur_label, d_idx);
  assign asg_caddr  = cd_addr;
  assign lbl_raddr  = cmd.lbl_rd_op ? PT_W'(point_index) : p_idx;
  assign cnt_raddr  = cmd.cnt_rd_lbl ? lbl_rd : c_idx;

  // Point memory: loads write, one read port.
  always_ff @(posedge clk) begin
    if (cmd.load && ld_ok) begin
      pt_mem[ld_addr] <= coordinate;
    end
    pt_rd <= pt_mem[pt_raddr];
  end

  // Centroid memory: seeding and mean updates write.
  always_ff @(posedge clk) begin
    if (seed_pend) begin
      cen_mem[seed_caddr] <= pt_rd;
    end else if (cmd.cen_wr_div) begin
      cen_mem[cd_addr] <= quot[15:0];
    end
    cen_rd <= cen_mem[asg_caddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_pend <= 1'b0;
    end else begin
      seed_pend <= cmd.seed_rd;
    end
  end

  always_ff @(posedge clk) begin
    seed_caddr <= cd_addr;
  end

  // Label memory: cleared after reset, written by the assign pipeline.
  always_ff @(posedge clk) begin
    if (cmd.lbl_clr) begin
      lbl_mem[p_idx] <= '0;
    end else if (t4.vld && t4.last_d && t4.last_c) begin
      lbl_mem[t4.pt] <= new_label;
    end
    lbl_rd <= lbl_mem[lbl_raddr];
  end

  // Sum memory: cleared each iteration, read-modify-write per coordinate.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      sum_mem[cd_addr] <= '0;
    end else if (cmd.acc_wr) begin
      sum_mem[ld_cd_addr] <= sum_rd + SUM_W'(pt_rd);
    end
    sum_rd <= sum_mem[cmd.acc_rd ? ld_cd_addr : cd_addr];
  end

  // Count memory: one increment per point.
  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      cnt_mem[c_idx] <= '0;
    end else if (cmd.cnt_wr) begin
      cnt_mem[cur_label] <= cnt_rd + 1'b1;
    end
    cnt_rd <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_rd_lbl) begin
      cur_label <= lbl_rd;
    end
  end

  // Distance pipeline: difference, square, accumulate, compare.
  assign diff1 = 17'(pt_rd) - 17'(cen_rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.vld <= 1'b0;
      t2.vld <= 1'b0;
      t3.vld <= 1'b0;
      t4.vld <= 1'b0;
    end else begin
      t1.vld <= cmd.asg_issue;
      t2.vld <= t1.vld;
      t3.vld <= t2.vld;
      t4.vld <= t3.vld;
    end
  end

  always_ff @(posedge clk) begin
    t1.first_d <= cmd.first_d;
    t1.last_d  <= cmd.last_d;
    t1.last_c  <= cmd.last_c;
    t1.cl      <= c_idx;
    t1.pt      <= p_idx;
    {t2.first_d, t2.last_d, t2.last_c, t2.cl, t2.pt} <=
      {t1.first_d, t1.last_d, t1.last_c, t1.cl, t1.pt};
    {t3.first_d, t3.last_d, t3.last_c, t3.cl, t3.pt} <=
      {t2.first_d, t2.last_d, t2.last_c, t2.cl, t2.pt};
    {t4.first_d, t4.last_d, t4.last_c, t4.cl, t4.pt} <=
      {t3.first_d, t3.last_d, t3.last_c, t3.cl, t3.pt};
    mag2 <= diff1[16] ? 16'(-diff1) : diff1[15:0];
    sq3  <= 32'(mag2) * 32'(mag2);
    if (t3.vld) begin
      acc4 <= t3.first_d ? DIST_W'(sq3) : acc4 + DIST_W'(sq3);
    end
  end

  // Ties keep the lower cluster index.
  assign take      = (t4.cl == '0) || (acc4 < best_d);
  assign new_label = take ? t4.cl : best_c;

  always_ff @(posedge clk) begin
    if (t4.vld && t4.last_d && take) begin
      best_d <= acc4;
      best_c <= t4.cl;
    end
  end

  // Mean division.
  kce_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_rd),
    .divisor  (cnt_rd),
    .done     (div_done),
    .quotient (quot)
  );

  assign stat.cnt_zero = (cnt_rd == '0);
  assign stat.div_done = div_done;

  // Result word register.
  always_ff @(posedge clk) begin
    if (cmd.lbl_rd_op) begin
      echo_hold <= point_index;
      echo_ok   <= int'(point_index) < MAX_POINTS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.res_read || cmd.res_run;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_run) begin
      point_echo    <= '0;
      cluster_label <= '0;
      run_done      <= 1'b1;
    end else begin
      point_echo    <= echo_hold;
      cluster_label <= echo_ok ? 3'(lbl_rd) : 3'd0;
      run_done      <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* rtl/kce_ctrl.sv */
// Controller: state machine sequencing seeding, assignment and mean updates.
`default_nettype none
module kce_ctrl #(
  parameter int DIMS         = 16,
  parameter int MAX_POINTS   = 256,
  parameter int MAX_CLUSTERS = 8,
  localparam int DIM_W   = (DIMS > 1) ? $clog2(DIMS) : 1,
  localparam int PT_W    = $clog2(MAX_POINTS),
  localparam int CL_W    = $clog2(MAX_CLUSTERS)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [1:0]         opcode,
  input  wire logic [3:0]         num_clusters,
  input  wire logic [8:0]         num_points,
  input  wire logic [9:0]         iteration_limit,
  input  wire kce_pkg::kce_stat_t stat,
  output logic                    busy,
  output kce_pkg::kce_cmd_t       cmd,
  output logic [PT_W-1:0]         p_idx,
  output logic [CL_W-1:0]         c_idx,
  output logic [DIM_W-1:0]        d_idx
);

  typedef enum logic [19:0] {
    S_INIT     = 20'b00000000000000000001,
    S_IDLE     = 20'b00000000000000000010,
    S_RDRES    = 20'b00000000000000000100,
    S_SEED     = 20'b00000000000000001000,
    S_SEEDW    = 20'b00000000000000010000,
    S_ASG      = 20'b00000000000000100000,
    S_DRAIN    = 20'b00000000000001000000,
    S_CLR      = 20'b00000000000010000000,
    S_ACC_LBL  = 20'b00000000000100000000,
    S_ACC_CNT  = 20'b00000000001000000000,
    S_ACC_CNTW = 20'b00000000010000000000,
    S_ACC_RD   = 20'b00000000100000000000,
    S_ACC_WR   = 20'b00000001000000000000,
    S_DIV_CNT  = 20'b00000010000000000000,
    S_DIV_CHK  = 20'b00000100000000000000,
    S_DIV_RD   = 20'b00001000000000000000,
    S_DIV_LD   = 20'b00010000000000000000,
    S_DIV_RUN  = 20'b00100000000000000000,
    S_DIV_WR   = 20'b01000000000000000000,
    S_DONE     = 20'b10000000000000000000
  } state_t;

  state_t state;
  logic [CL_W-1:0]    k_last;
  logic [PT_W-1:0]    n_last;
  logic [9:0]         iter;
  logic [kce_pkg::DRAIN_W-1:0] drain;
  logic               accept;
  logic               last_d;
  logic               last_c;
  logic               last_p;
  logic               last_it;
  logic [CL_W-1:0]    k_last_next;
  logic [PT_W-1:0]    n_last_next;
  int                 kv;
  int                 nv;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign last_d  = (d_idx == DIM_W'(DIMS - 1));
  assign last_c  = (c_idx == k_last);
  assign last_p  = (p_idx == n_last);
  assign last_it = (iter == iteration_limit - 10'd1);

  // Clamp the cluster and point counts to their usable ranges.
  always_comb begin
    kv = int'(num_clusters);
    nv = int'(num_points);
    if (kv < 1) kv = 1;
    if (kv > MAX_CLUSTERS) kv = MAX_CLUSTERS;
    if (kv > MAX_POINTS) kv = MAX_POINTS;
    if (nv < 1) nv = 1;
    if (nv > MAX_POINTS) nv = MAX_POINTS;
    k_last_next = CL_W'(kv - 1);
    n_last_next = PT_W'(nv - 1);
  end

  // Command decode per state.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load      = accept && (opcode == kce_pkg::OP_LOAD);
        cmd.lbl_rd_op = accept && (opcode == kce_pkg::OP_READ);
      end
      S_INIT:     cmd.lbl_clr = 1'b1;
      S_RDRES:    cmd.res_read = 1'b1;
      S_SEED:     cmd.seed_rd = 1'b1;
      S_ASG: begin
        cmd.asg_issue = 1'b1;
        cmd.first_d   = (d_idx == '0);
        cmd.last_d    = last_d;
        cmd.last_c    = last_c;
      end
      S_CLR: begin
        cmd.clr_wr  = 1'b1;
        cmd.cnt_clr = (d_idx == '0);
      end
      S_ACC_CNT:  cmd.cnt_rd_lbl = 1'b1;
      S_ACC_CNTW: cmd.cnt_wr = 1'b1;
      S_ACC_RD:   cmd.acc_rd = 1'b1;
      S_ACC_WR:   cmd.acc_wr = 1'b1;
      S_DIV_LD:   cmd.div_start = 1'b1;
      S_DIV_WR:   cmd.cen_wr_div = 1'b1;
      S_DONE:     cmd.res_run = 1'b1;
      default: ;
    endcase
  end

  // Sequencing and loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      p_idx  <= '0;
      c_idx  <= '0;
      d_idx  <= '0;
      iter   <= '0;
      drain  <= '0;
      k_last <= '0;
      n_last <= '0;
    end else begin
      unique case (state)
        S_INIT: begin
          p_idx <= p_idx + 1'b1;
          if (p_idx == PT_W'(MAX_POINTS - 1)) begin
            p_idx <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && (opcode == kce_pkg::OP_RUN)) begin
            k_last <= k_last_next;
            n_last <= n_last_next;
            c_idx  <= '0;
            d_idx  <= '0;
            state  <= S_SEED;
          end else if (accept && (opcode == kce_pkg::OP_READ)) begin
            state <= S_RDRES;
          end
        end
        S_RDRES: state <= S_IDLE;
        S_SEED: begin
          d_idx <= d_idx + 1'b1;
          if (last_d) begin
            d_idx <= '0;
            c_idx <= c_idx + 1'b1;
            if (last_c) begin
              c_idx <= '0;
              state <= S_SEEDW;
            end
          end
        end
        S_SEEDW: begin
          p_idx <= '0;
          iter  <= '0;
          state <= (iteration_limit == '0) ? S_DONE : S_ASG;
        end
        S_ASG: begin
          d_idx <= d_idx + 1'b1;
          if (last_d) begin
            d_idx <= '0;
            c_idx <= c_idx + 1'b1;
            if (last_c) begin
              c_idx <= '0;
              p_idx <= p_idx + 1'b1;
              if (last_p) begin
                p_idx <= '0;
                drain <= '0;
                state <= S_DRAIN;
              end
            end
          end
        end
        S_DRAIN: begin
          drain <= drain + 1'b1;
          if (drain == kce_pkg::DRAIN_W'(kce_pkg::DRAIN_CYCLES - 1)) begin
            state <= S_CLR;
          end
        end
        S_CLR: begin
          d_idx <= d_idx + 1'b1;
          if (last_d) begin
            d_idx <= '0;
            c_idx <= c_idx + 1'b1;
            if (last_c) begin
              c_idx <= '0;
              p_idx <= '0;
              state <= S_ACC_LBL;
            end
          end
        end
        S_ACC_LBL:  state <= S_ACC_CNT;
        S_ACC_CNT:  state <= S_ACC_CNTW;
        S_ACC_CNTW: state <= S_ACC_RD;
        S_ACC_RD:   state <= S_ACC_WR;
        S_ACC_WR: begin
          d_idx <= d_idx + 1'b1;
          state <= S_ACC_RD;
          if (last_d) begin
            d_idx <= '0;
            p_idx <= p_idx + 1'b1;
            state <= S_ACC_LBL;
            if (last_p) begin
              p_idx <= '0;
              c_idx <= '0;
              state <= S_DIV_CNT;
            end
          end
        end
        S_DIV_CNT: state <= S_DIV_CHK;
        S_DIV_CHK: begin
          d_idx <= '0;
          if (!stat.cnt_zero) begin
            state <= S_DIV_RD;
          end else if (!last_c) begin
            c_idx <= c_idx + 1'b1;
            state <= S_DIV_CNT;
          end else begin
            c_idx <= '0;
            iter  <= iter + 1'b1;
            state <= last_it ? S_DONE : S_ASG;
          end
        end
        S_DIV_RD: state <= S_DIV_LD;
        S_DIV_LD: state <= S_DIV_RUN;
        S_DIV_RUN: begin
          if (stat.div_done) begin
            state <= S_DIV_WR;
          end
        end
        S_DIV_WR: begin
          d_idx <= d_idx + 1'b1;
          state <= S_DIV_RD;
          if (last_d) begin
            d_idx <= '0;
            if (!last_c) begin
              c_idx <= c_idx + 1'b1;
              state <= S_DIV_CNT;
            end else begin
              c_idx <= '0;
              iter  <= iter + 1'b1;
              state <= last_it ? S_DONE : S_ASG;
            end
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Testbench for the k-means cluster engine: loads, runs and label reads against a model.
module tb_top;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NPTS = 256;
  localparam int NDIM = 16;
  localparam int NCLU = 8;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int SETTLE_CYCLES = 24;

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] coord;
    logic [7:0]         pidx;
    logic [3:0]         didx;
  } cmd_word_t;

  typedef struct {
    logic [7:0] echo;
    logic [2:0] label;
    logic       done;
  } result_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] opcode = '0;
  logic signed [15:0] coordinate = '0;
  logic [7:0] point_index = '0;
  logic [3:0] dim_index = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire busy, result_strobe, run_done, pready;
  wire [7:0] point_echo;
  wire [2:0] cluster_label;
  wire [31:0] prdata;

  kmeans_cluster_engine dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .coordinate(coordinate), .point_index(point_index), .dim_index(dim_index),
    .result_strobe(result_strobe), .point_echo(point_echo),
    .cluster_label(cluster_label), .run_done(run_done), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // Model copy of the engine state and registers.
  logic signed [15:0] coord_mem [NPTS][NDIM];
  logic signed [15:0] centroid_mem [NCLU][NDIM];
  logic [2:0] label_mem [NPTS];
  logic [3:0] k_reg = 4'd5;
  logic [8:0] n_reg = 9'd256;
  logic [9:0] iter_reg = 10'd300;

  cmd_word_t cmd_queue [$];
  result_word_t label_expect [$];
  int gap_left = 0;
  int errors = 0;
  int issued = 0;
  int runs_done = 0;
  int reads_done = 0;
  int cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report(input string what);
    $display("tb_top: mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // Squared Euclidean distance of a point to a centroid.
  function automatic longint sq_dist(input int p, input int c);
    longint acc;
    int diff;
    acc = 0;
    for (int d = 0; d < NDIM; d++) begin
      diff = int'(coord_mem[p][d]) - int'(centroid_mem[c][d]);
      acc += longint'(diff) * longint'(diff);
    end
    return acc;
  endfunction

  // Assign and recompute iterations with the current register settings.
  task automatic cluster_run();
    int k, n, best, members [NCLU];
    longint best_d, dd, sums [NCLU][NDIM];
    k = (k_reg < 1) ? 1 : ((k_reg > NCLU) ? NCLU : int'(k_reg));
    n = (n_reg < 1) ? 1 : ((n_reg > NPTS) ? NPTS : int'(n_reg));
    for (int c = 0; c < k; c++)
      for (int d = 0; d < NDIM; d++) centroid_mem[c][d] = coord_mem[c][d];
    for (int it = 0; it < int'(iter_reg); it++) begin
      for (int p = 0; p < n; p++) begin
        best = 0;
        best_d = sq_dist(p, 0);
        for (int c = 1; c < k; c++) begin
          dd = sq_dist(p, c);
          if (dd < best_d) begin
            best_d = dd;
            best = c;
          end
        end
        label_mem[p] = best[2:0];
      end
      for (int c = 0; c < NCLU; c++) begin
        members[c] = 0;
        for (int d = 0; d < NDIM; d++) sums[c][d] = 0;
      end
      for (int p = 0; p < n; p++) begin
        members[label_mem[p]]++;
        for (int d = 0; d < NDIM; d++) sums[label_mem[p]][d] += longint'(coord_mem[p][d]);
      end
      // An empty cluster keeps its old centroid.
      for (int c = 0; c < k; c++)
        if (members[c] != 0)
          for (int d = 0; d < NDIM; d++)
            centroid_mem[c][d] = 16'(sums[c][d] / longint'(members[c]));
    end
  endtask

  // Apply one accepted word to the model and queue the result word of a run or a read.
  task automatic predict_word();
    result_word_t r;
    case (opcode)
      kce_pkg::OP_LOAD: coord_mem[point_index][dim_index] = coordinate;
      kce_pkg::OP_RUN: begin
        cluster_run();
        r.echo = '0; r.label = '0; r.done = 1'b1;
        label_expect.insert(label_expect.size(), r);
        runs_done++;
      end
      kce_pkg::OP_READ: begin
        r.echo = point_index; r.label = label_mem[point_index]; r.done = 1'b0;
        label_expect.insert(label_expect.size(), r);
        reads_done++;
      end
      default: ;
    endcase
  endtask

  // Command driver with random gaps between words.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) predict_word();
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        opcode <= cmd_queue[0].op;
        coordinate <= cmd_queue[0].coord;
        point_index <= cmd_queue[0].pidx;
        dim_index <= cmd_queue[0].didx;
        void'(cmd_queue.pop_front());
        start <= 1'b1;
        case ($urandom_range(0, 19))
          0, 1, 2: gap_left <= $urandom_range(1, 3);
          3: gap_left <= $urandom_range(10, 60);
          default: gap_left <= 0;
        endcase
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor: compare each strobed word with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (label_expect.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        if (point_echo !== label_expect[0].echo)
          report($sformatf("point_echo %0d, expected %0d", point_echo, label_expect[0].echo));
        if (cluster_label !== label_expect[0].label)
          report($sformatf("cluster_label %0d, expected %0d (point %0d)",
                           cluster_label, label_expect[0].label, label_expect[0].echo));
        if (run_done !== label_expect[0].done)
          report($sformatf("run_done %0b, expected %0b", run_done, label_expect[0].done));
        void'(label_expect.pop_front());
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic push_word(input logic [1:0] op, input logic signed [15:0] v,
                           input logic [7:0] p, input logic [3:0] d);
    cmd_word_t w;
    w.op = op; w.coord = v; w.pidx = p; w.didx = d;
    cmd_queue.insert(cmd_queue.size(), w);
    issued++;
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2, 3: return 16'($urandom());
      default: return 16'($urandom_range(0, 400)) - 16'sd200;
    endcase
  endfunction

  // Wait until the engine has drained every word and result.
  task automatic wait_idle();
    while (cmd_queue.size() != 0 || start || label_expect.size() != 0 || busy)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      kce_pkg::REG_NUM_CLUSTERS: k_reg = val[3:0];
      kce_pkg::REG_NUM_POINTS: n_reg = val[8:0];
      default: iter_reg = val[9:0];
    endcase
  endtask

  task automatic set_regs(input int k, input int n, input int iters);
    wait_idle();
    reg_write(kce_pkg::REG_NUM_CLUSTERS, k);
    reg_write(kce_pkg::REG_NUM_POINTS, n);
    reg_write(kce_pkg::REG_ITERATION_LIMIT, iters);
  endtask

  task automatic run_and_read(input int nreads);
    push_word(kce_pkg::OP_RUN, rand_coord(), 8'($urandom()), 4'($urandom()));
    for (int i = 0; i < nreads; i++)
      push_word(kce_pkg::OP_READ, rand_coord(), 8'($urandom_range(0, 15)), 4'($urandom()));
  endtask

  // Stimulus sequence.
  initial begin
    int sel, p, k, n;
    for (int i = 0; i < NPTS; i++) label_mem[i] = '0;
    for (int c = 0; c < NCLU; c++)
      for (int d = 0; d < NDIM; d++) centroid_mem[c][d] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_regs(3, 8, 2);

    // Fill the first sixteen points so that any small run reads stored data.
    for (int i = 0; i < 16; i++)
      for (int d = 0; d < NDIM; d++) push_word(kce_pkg::OP_LOAD, rand_coord(), 8'(i), 4'(d));

    // Directed words: coordinate extremes, ignored opcode, read extremes, a run.
    push_word(kce_pkg::OP_LOAD, 16'sh8000, 8'd0, 4'd0);
    push_word(kce_pkg::OP_LOAD, 16'sh7fff, 8'd0, 4'd15);
    push_word(kce_pkg::OP_LOAD, 16'sh7fff, 8'd15, 4'd0);
    push_word(kce_pkg::OP_LOAD, 16'sh8000, 8'd15, 4'd15);
    push_word(kce_pkg::OP_READ, 16'sh0, 8'd0, 4'd0);
    push_word(kce_pkg::OP_READ, 16'sh0, 8'd255, 4'd15);
    push_word(OP_UNUSED, 16'sh7fff, 8'd255, 4'd15);
    push_word(OP_UNUSED, 16'sh0, 8'd0, 4'd0);
    run_and_read(8);
    push_word(kce_pkg::OP_READ, 16'sh0, 8'd200, 4'd0);

    // Register corner cases: zero values, more clusters than points, clamping.
    set_regs(0, 0, 0);
    run_and_read(3);
    set_regs(8, 1, 1);
    run_and_read(4);
    set_regs(15, 2, 1);
    run_and_read(4);
    set_regs(1, 1, 1023);
    run_and_read(2);

    // Random phases: mostly loads and reads with occasional runs.
    while (issued < 600) begin
      k = $urandom_range(1, 8);
      n = $urandom_range(1, 12);
      set_regs(k, n, $urandom_range(1, 3));
      for (int i = 0; i < 40; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
          p = $urandom_range(0, 15);
          for (int d = 0; d < NDIM; d++)
            push_word(kce_pkg::OP_LOAD, rand_coord(), 8'(p), 4'(d));
        end else if (sel < 40) begin
          push_word(kce_pkg::OP_LOAD, rand_coord(), 8'($urandom()), 4'($urandom()));
        end else if (sel < 88) begin
          push_word(kce_pkg::OP_READ, rand_coord(), 8'($urandom()), 4'($urandom()));
        end else if (sel < 93) begin
          run_and_read(2);
        end else begin
          push_word(OP_UNUSED, rand_coord(), 8'($urandom()), 4'($urandom()));
        end
      end
    end

    // Clamped cluster count over all sixteen filled points.
    set_regs(15, 16, 2);
    push_word(kce_pkg::OP_RUN, 16'sh0, 8'd0, 4'd0);
    for (int i = 0; i < 20; i++)
      push_word(kce_pkg::OP_READ, 16'sh0, 8'($urandom()), 4'($urandom()));

    wait_idle();
    $display("tb_top: %0d words issued, %0d runs and %0d label reads checked", issued,
             runs_done, reads_done);
    $display("tb_top: covered register clamping, empty clusters and ignored opcodes");
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
